[rtl/spq_pkg.sv]
// shared types, codes and defaults of the sorted priority queue
package spq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned POS_W           = 4;
    localparam int unsigned OCC_W           = 5;

    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_EMPTY     = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

[rtl/spq_ctrl.sv]
// controller: item handshake, execute sequencing and result valid
module spq_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output spq_pkg::cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = out_valid_reg;
    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.commit  = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_commit_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("commit did not return to idle with a result");

    a_capture_goes_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_EXEC))
        else $error("captured item not executed");

    a_no_capture_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> !cmd.capture)
        else $error("item captured while busy");

endmodule

[rtl/spq_datapath.sv]
// datapath: sorted cell chain, parallel compare, search encoder and result register
module spq_datapath
#(
    parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  spq_pkg::cmd_t                     cmd,
    input  logic [1:0]                        in_opcode,
    input  logic signed [spq_pkg::DATA_W-1:0] in_data,
    input  logic signed [spq_pkg::DATA_W-1:0] in_priority,
    output logic signed [spq_pkg::DATA_W-1:0] out_data,
    output logic signed [spq_pkg::DATA_W-1:0] out_priority,
    output logic [spq_pkg::POS_W-1:0]         found_position,
    output logic [1:0]                        status,
    output logic [spq_pkg::OCC_W-1:0]         occupancy
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned DW = spq_pkg::DATA_W;

    spq_pkg::opcode_t  op_reg;
    logic signed [DW-1:0] key_reg;
    logic signed [DW-1:0] pri_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;

    logic signed [DW-1:0] data_reg [QUEUE_DEPTH];
    logic signed [DW-1:0] prio_reg [QUEUE_DEPTH];
    logic signed [DW-1:0] data_next [QUEUE_DEPTH];
    logic signed [DW-1:0] prio_next [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] live;
    logic [QUEUE_DEPTH-1:0] gt;
    logic [QUEUE_DEPTH-1:0] hit;
    logic                   full;
    logic                   empty;
    logic                   do_enq;
    logic                   do_deq;
    logic                   found;
    logic [PW-1:0]          pos;

    logic signed [DW-1:0]       res_data_next;
    logic signed [DW-1:0]       res_prio_next;
    logic [PW+spq_pkg::POS_W-1:0] res_pos_ext;
    logic [CW+spq_pkg::OCC_W-1:0] occ_ext;
    spq_pkg::status_t           res_status_next;

    logic signed [DW-1:0]       res_data_reg;
    logic signed [DW-1:0]       res_prio_reg;
    logic [spq_pkg::POS_W-1:0]  res_pos_reg;
    spq_pkg::status_t           res_status_reg;
    logic [spq_pkg::OCC_W-1:0]  res_occ_reg;

    assign full   = (cnt_reg == CW'(QUEUE_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_enq = (op_reg == spq_pkg::OP_ENQ) && !full;
    assign do_deq = (op_reg == spq_pkg::OP_DEQ) && !empty;

    // per-cell compare and shift
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            assign live[gi] = (CW'(gi) < cnt_reg);
            assign gt[gi]   = live[gi] && (prio_reg[gi] > pri_reg);
            assign hit[gi]  = live[gi] && (data_reg[gi] == key_reg);

            logic ins_here;
            if (gi == 0)
            begin : g_head
                assign ins_here = 1'b1;
            end
            else
            begin : g_body
                assign ins_here = gt[gi-1];
            end

            always_comb
            begin
                data_next[gi] = data_reg[gi];
                prio_next[gi] = prio_reg[gi];
                if (do_enq && !gt[gi])
                begin
                    if (ins_here)
                    begin
                        data_next[gi] = key_reg;
                        prio_next[gi] = pri_reg;
                    end
                    else
                    begin
                        data_next[gi] = data_reg[(gi + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                        prio_next[gi] = prio_reg[(gi + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                    end
                end
                else if (do_deq && (gi < QUEUE_DEPTH - 1))
                begin
                    data_next[gi] = data_reg[(gi + 1) % QUEUE_DEPTH];
                    prio_next[gi] = prio_reg[(gi + 1) % QUEUE_DEPTH];
                end
            end
        end
    endgenerate

    // first match from the head
    always_comb
    begin
        found = 1'b0;
        pos   = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                found = 1'b1;
                pos   = PW'(i);
            end
        end
    end

    always_comb
    begin
        res_data_next   = '0;
        res_prio_next   = '0;
        res_pos_ext     = '0;
        res_status_next = spq_pkg::STS_OK;
        cnt_next        = cnt_reg;
        unique case (op_reg)
            spq_pkg::OP_ENQ:
            begin
                if (full)
                begin
                    res_status_next = spq_pkg::STS_FULL;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            spq_pkg::OP_DEQ:
            begin
                if (empty)
                begin
                    res_status_next = spq_pkg::STS_EMPTY;
                end
                else
                begin
                    res_data_next = data_reg[0];
                    res_prio_next = prio_reg[0];
                    cnt_next      = cnt_reg - CW'(1);
                end
            end
            spq_pkg::OP_SEARCH:
            begin
                if (found)
                begin
                    res_pos_ext = {{spq_pkg::POS_W{1'b0}}, pos};
                end
                else
                begin
                    res_status_next = spq_pkg::STS_NOT_FOUND;
                end
            end
            spq_pkg::OP_NOP:
            begin
                res_status_next = spq_pkg::STS_OK;
            end
        endcase
        occ_ext = {{spq_pkg::OCC_W{1'b0}}, cnt_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= spq_pkg::opcode_t'(in_opcode);
            key_reg <= in_data;
            pri_reg <= in_priority;
        end
        if (cmd.commit)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                data_reg[i] <= data_next[i];
                prio_reg[i] <= prio_next[i];
            end
            res_data_reg   <= res_data_next;
            res_prio_reg   <= res_prio_next;
            res_pos_reg    <= res_pos_ext[spq_pkg::POS_W-1:0];
            res_status_reg <= res_status_next;
            res_occ_reg    <= occ_ext[spq_pkg::OCC_W-1:0];
        end
    end

    assign out_data       = res_data_reg;
    assign out_priority   = res_prio_reg;
    assign found_position = res_pos_reg;
    assign status         = res_status_reg;
    assign occupancy      = res_occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && do_enq |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("enqueue did not add an entry");

    a_deq_shifts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && do_deq && (cnt_reg > CW'(1)) |=>
            data_reg[0] == $past(data_reg[1]) && prio_reg[0] == $past(prio_reg[1]))
        else $error("dequeue did not advance the head");

endmodule

[rtl/sorted_priority_queue.sv]
// top level of the sorted priority queue
//
//  channel  dir  tdata                                          tuser
//  s_*      in   item_data, item_priority                       opcode
//  m_*      out  out_data, out_priority, found_position, occ    status
//
// an item is captured in the idle state and executed in the exec state, so
// the block takes no new item until the last one executes; all cells
// compare and shift as it executes; the result sits in an output register;
// a stalled m_tready holds execution of the next item only, not its capture
// reset clears the entry count and handshake state, entries need no clearing
module sorted_priority_queue
#(
    parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // item_data[31:0], item_priority[63:32]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // out_data[31:0], out_priority[63:32],
                                   // found_position[67:64], occupancy[72:68]
    output logic [1:0]  m_tuser    // status[1:0]
);

    spq_pkg::cmd_t cmd;

    logic signed [spq_pkg::DATA_W-1:0] out_data;
    logic signed [spq_pkg::DATA_W-1:0] out_priority;
    logic [spq_pkg::POS_W-1:0]         found_position;
    logic [spq_pkg::OCC_W-1:0]         occupancy;

    spq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .in_opcode      (s_tuser),
        .in_data        (s_tdata[31:0]),
        .in_priority    (s_tdata[63:32]),
        .out_data       (out_data),
        .out_priority   (out_priority),
        .found_position (found_position),
        .status         (m_tuser),
        .occupancy      (occupancy)
    );

    assign m_tdata = {7'd0, occupancy, found_position, out_priority, out_data};

endmodule
